@@ rtl/bfa_pkg.sv @@
// Shared types and constants for the best-fit block allocator.
`default_nettype none
package bfa_pkg;
  localparam int SW = 24;
  localparam int NUM_HEADERS_DEF = 32;
  localparam logic [SW-1:0] ARENA_RESET = 24'd65536;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  typedef struct packed {
    logic          free;
    logic [SW-1:0] size;
  } hdr_t;
endpackage
`default_nettype wire

@@ rtl/bfa_hdr_mem.sv @@
// Header table storage: one write port, one registered read port.
`default_nettype none
module bfa_hdr_mem #(
  parameter int NUM_HEADERS = bfa_pkg::NUM_HEADERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(NUM_HEADERS)-1:0] waddr,
  input  wire bfa_pkg::hdr_t                  wdata,
  input  wire logic [$clog2(NUM_HEADERS)-1:0] raddr,
  output      bfa_pkg::hdr_t                  rdata
);
  bfa_pkg::hdr_t mem [NUM_HEADERS];
  bfa_pkg::hdr_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ rtl/best_fit_block_allocator.sv @@
// Top level of the best-fit block allocator: sequencer over the header table.
`default_nettype none
// A request word is taken when start is high and busy is low; its one result
// word shows on the out_ ports for a single cycle with out_valid and cannot be
// held off. Headers live in a table with one write port and one registered
// read port, and every request but a zero-size allocate is a walk by one
// shared add/compare unit. After reset and after every cfg write the table is
// cleared (busy high). An allocate of size zero answers in the cycle after it
// is taken. Otherwise an allocate runs a best-fit scan, then the lower-neighbor
// walk, the upper neighbor, the empty-slot search and the shift as needed. A
// release runs an offset scan and then the lower-neighbor walk. cfg_ready is
// always high; a cfg write reloads arena_size and restarts the clear.
module best_fit_block_allocator #(
  parameter int NUM_HEADERS = bfa_pkg::NUM_HEADERS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic                   in_operation,
  input  wire logic [bfa_pkg::SW-1:0] in_request_size,
  input  wire logic [bfa_pkg::SW-1:0] in_release_offset,
  output      logic                   out_valid,
  output      logic [1:0]             out_status,
  output      logic [bfa_pkg::SW-1:0] out_block_offset,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [bfa_pkg::SW-1:0] cfg_data
);
  localparam int SW = bfa_pkg::SW;
  localparam int IW = $clog2(NUM_HEADERS);
  localparam int OW = SW + IW;  // running offset never wraps
  localparam logic [IW-1:0] LAST = IW'(NUM_HEADERS - 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_SC_RD  = 5'd2;
  localparam logic [4:0] S_SC_EV  = 5'd3;
  localparam logic [4:0] S_LN_RD  = 5'd4;
  localparam logic [4:0] S_LN_EV  = 5'd5;
  localparam logic [4:0] S_LN_END = 5'd6;
  localparam logic [4:0] S_UP_RD  = 5'd7;
  localparam logic [4:0] S_UP_EV  = 5'd8;
  localparam logic [4:0] S_FE_RD  = 5'd9;
  localparam logic [4:0] S_FE_EV  = 5'd10;
  localparam logic [4:0] S_SH_RD  = 5'd11;
  localparam logic [4:0] S_SH_WR  = 5'd12;
  localparam logic [4:0] S_SH_END = 5'd13;
  localparam logic [4:0] S_FIN_RD = 5'd14;
  localparam logic [4:0] S_FIN_EV = 5'd15;
  localparam logic [4:0] S_RL_RD  = 5'd16;
  localparam logic [4:0] S_RL_EV  = 5'd17;
  localparam logic [4:0] S_RU_RD  = 5'd18;
  localparam logic [4:0] S_RU_EV  = 5'd19;
  localparam logic [4:0] S_RW     = 5'd20;
  localparam logic [4:0] S_RM_RD  = 5'd21;
  localparam logic [4:0] S_RM_EV  = 5'd22;

  // sequencer state
  logic [4:0]    st_r, st_nxt;
  logic [IW-1:0] k_r, k_nxt;        // walk index
  logic [IW-1:0] b_r, b_nxt;        // chosen / released header
  logic [IW-1:0] dest_r, dest_nxt;  // where leftover goes
  logic [IW-1:0] e_r, e_nxt;        // empty slot for shift
  logic [OW-1:0] off_r, off_nxt;
  logic [OW-1:0] boff_r, boff_nxt;
  logic [SW-1:0] arena_r;
  logic [SW-1:0] req_r, req_nxt;
  logic [SW-1:0] where_r, where_nxt;
  logic [SW-1:0] bsz_r, bsz_nxt;    // best block size / released size
  logic [SW-1:0] bdiff_r, bdiff_nxt;
  logic          bfound_r, bfound_nxt;
  logic          below_r, below_nxt;
  logic          lnf_r, lnf_nxt;
  logic          op_r, op_nxt;
  logic          sh_up_r, sh_up_nxt;  // shift direction: entries move down
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [SW-1:0] ob_r, ob_nxt;

  // table port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  bfa_pkg::hdr_t wdata, rd;

  // shared arithmetic
  logic [SW-1:0] diff;
  logic          fits, empty;
  logic [OW-1:0] off_sum;

  bfa_hdr_mem #(.NUM_HEADERS(NUM_HEADERS)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd)
  );

  assign diff    = rd.size - req_r;
  assign fits    = rd.free && (rd.size >= req_r);
  assign empty   = rd.free && (rd.size == '0);
  assign off_sum = off_r + OW'(rd.size);

  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_block_offset = ob_r;

  always_comb begin
    st_nxt = st_r; k_nxt = k_r; b_nxt = b_r; dest_nxt = dest_r; e_nxt = e_r;
    off_nxt = off_r; boff_nxt = boff_r; req_nxt = req_r; where_nxt = where_r;
    bsz_nxt = bsz_r; bdiff_nxt = bdiff_r; bfound_nxt = bfound_r;
    below_nxt = below_r; lnf_nxt = lnf_r; op_nxt = op_r; sh_up_nxt = sh_up_r;
    ov_nxt = 1'b0; os_nxt = os_r; ob_nxt = ob_r;
    we = 1'b0; waddr = k_r; wdata = rd; raddr = k_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_operation; req_nxt = in_request_size;
          where_nxt = in_release_offset;
          k_nxt = '0; off_nxt = '0; bfound_nxt = 1'b0; below_nxt = 1'b0;
          if (in_operation == bfa_pkg::OP_RELEASE) begin
            st_nxt = S_RL_RD;
          end else if (in_request_size == '0) begin
            ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_NO_FIT; ob_nxt = '0;
          end else begin
            st_nxt = S_SC_RD;
          end
        end
      end
      S_CLR: begin
        we = 1'b1; waddr = k_r;
        wdata.free = 1'b1;
        wdata.size = (k_r == '0) ? arena_r : '0;
        if (k_r == LAST) st_nxt = S_IDLE;
        else k_nxt = k_r + 1'b1;
      end
      // best-fit scan
      S_SC_RD: st_nxt = S_SC_EV;
      S_SC_EV: begin
        st_nxt = S_SC_RD;
        off_nxt = off_sum;
        if (fits && diff == '0) begin
          we = 1'b1; waddr = k_r; wdata.free = 1'b0; wdata.size = rd.size;
          ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_OK; ob_nxt = off_r[SW-1:0];
          st_nxt = S_IDLE;
        end else begin
          if (fits && (!bfound_r || diff < bdiff_r)) begin
            bfound_nxt = 1'b1; b_nxt = k_r; bdiff_nxt = diff;
            boff_nxt = off_r; bsz_nxt = rd.size;
          end
          if (k_r == LAST) begin
            if (!(bfound_r || fits)) begin
              ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_NO_FIT; ob_nxt = '0;
              st_nxt = S_IDLE;
            end else begin
              // b_nxt already valid here
              lnf_nxt = 1'b0;
              if (b_nxt == '0) st_nxt = S_LN_END;
              else begin
                k_nxt = b_nxt - 1'b1; st_nxt = S_LN_RD;
              end
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      // lower-neighbor walk from b_r
      S_LN_RD: st_nxt = S_LN_EV;
      S_LN_EV: begin
        st_nxt = S_LN_END;
        if (!rd.free) begin
          lnf_nxt = (k_r + 1'b1 != b_r);
          dest_nxt = k_r + 1'b1;
        end else if (rd.size != '0) begin
          lnf_nxt = 1'b1; dest_nxt = k_r;
        end else if (k_r == '0) begin
          lnf_nxt = 1'b0;
        end else begin
          k_nxt = k_r - 1'b1; st_nxt = S_LN_RD;
        end
      end
      S_LN_END: begin
        if (op_r == bfa_pkg::OP_RELEASE) begin
          if (lnf_r) st_nxt = S_RM_RD;
          else begin
            ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_OK; ob_nxt = '0;
            st_nxt = S_IDLE;
          end
        end else if (lnf_r) begin
          below_nxt = 1'b1; st_nxt = S_FIN_RD;
        end else if (b_r != LAST) begin
          k_nxt = b_r + 1'b1; st_nxt = S_UP_RD;
        end else begin
          k_nxt = '0; st_nxt = S_FE_RD;
        end
      end
      // higher neighbor
      S_UP_RD: st_nxt = S_UP_EV;
      S_UP_EV: begin
        if (rd.free) begin
          dest_nxt = k_r; st_nxt = S_FIN_RD;
        end else begin
          k_nxt = '0; st_nxt = S_FE_RD;
        end
      end
      // first empty slot
      S_FE_RD: st_nxt = S_FE_EV;
      S_FE_EV: begin
        st_nxt = S_FE_RD;
        if (empty) begin
          e_nxt = k_r;
          if (k_r < b_r) begin
            sh_up_nxt = 1'b1; dest_nxt = b_r; st_nxt = S_SH_RD;
          end else begin
            sh_up_nxt = 1'b0; dest_nxt = b_r + 1'b1;
            st_nxt = (k_r > b_r + 1'b1) ? S_SH_RD : S_SH_END;
          end
        end else if (k_r == LAST) begin
          // no room to split: grant unsplit
          we = 1'b1; waddr = b_r; wdata.free = 1'b0; wdata.size = bsz_r;
          ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_OK; ob_nxt = boff_r[SW-1:0];
          st_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // shift entries toward the empty slot
      S_SH_RD: begin
        raddr = sh_up_r ? k_r + 1'b1 : k_r - 1'b1;
        st_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we = 1'b1; waddr = k_r; wdata = rd;
        st_nxt = S_SH_RD;
        if (sh_up_r) begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == b_r) begin
            b_nxt = b_r - 1'b1; st_nxt = S_SH_END;
          end
        end else begin
          k_nxt = k_r - 1'b1;
          if (k_r - 1'b1 == b_r + 1'b1) st_nxt = S_SH_END;
        end
      end
      S_SH_END: begin
        we = 1'b1; waddr = dest_r; wdata.free = 1'b1; wdata.size = '0;
        st_nxt = S_FIN_RD;
      end
      // grant: shrink chosen block, grow destination
      S_FIN_RD: begin
        we = 1'b1; waddr = b_r; wdata.free = 1'b0; wdata.size = req_r;
        raddr = dest_r;
        st_nxt = S_FIN_EV;
      end
      S_FIN_EV: begin
        we = 1'b1; waddr = dest_r; wdata.free = rd.free;
        wdata.size = rd.size + bdiff_r;
        ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_OK;
        ob_nxt = boff_r[SW-1:0] + (below_r ? bdiff_r : '0);
        st_nxt = S_IDLE;
      end
      // release: offset match scan
      S_RL_RD: st_nxt = S_RL_EV;
      S_RL_EV: begin
        off_nxt = off_sum;
        st_nxt = S_RL_RD;
        if (off_r == OW'(where_r) && !empty) begin
          b_nxt = k_r; bsz_nxt = rd.size;
          if (k_r != LAST) begin
            k_nxt = k_r + 1'b1; st_nxt = S_RU_RD;
          end else begin
            st_nxt = S_RW;
          end
        end else if (k_r == LAST) begin
          ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_NOT_FOUND; ob_nxt = '0;
          st_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_RU_RD: st_nxt = S_RU_EV;
      S_RU_EV: begin
        if (rd.free) begin
          bsz_nxt = bsz_r + rd.size;
          we = 1'b1; waddr = k_r; wdata.free = 1'b1; wdata.size = '0;
        end
        st_nxt = S_RW;
      end
      S_RW: begin
        we = 1'b1; waddr = b_r; wdata.free = 1'b1; wdata.size = bsz_r;
        lnf_nxt = 1'b0;
        if (b_r == '0) st_nxt = S_LN_END;
        else begin
          k_nxt = b_r - 1'b1; st_nxt = S_LN_RD;
        end
      end
      // merge into lower neighbor
      S_RM_RD: begin
        we = 1'b1; waddr = b_r; wdata.free = 1'b1; wdata.size = '0;
        raddr = dest_r;
        st_nxt = S_RM_EV;
      end
      S_RM_EV: begin
        we = 1'b1; waddr = dest_r; wdata.free = rd.free;
        wdata.size = rd.size + bsz_r;
        ov_nxt = 1'b1; os_nxt = bfa_pkg::ST_OK; ob_nxt = '0;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_valid) begin
      st_nxt = S_CLR; k_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      k_r     <= '0;
      arena_r <= bfa_pkg::ARENA_RESET;
      ov_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid) arena_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt; dest_r <= dest_nxt; e_r <= e_nxt;
    off_r <= off_nxt; boff_r <= boff_nxt; req_r <= req_nxt;
    where_r <= where_nxt; bsz_r <= bsz_nxt; bdiff_r <= bdiff_nxt;
    bfound_r <= bfound_nxt; below_r <= below_nxt; lnf_r <= lnf_nxt;
    op_r <= op_nxt; sh_up_r <= sh_up_nxt; os_r <= os_nxt; ob_r <= ob_nxt;
  end

  // first shift write lands on the empty slot found by the search
  a_shift_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SH_WR && $past(st_r) == S_SH_RD && $past(st_r, 2) == S_FE_EV)
      |-> k_r == e_r)
    else $error("shift did not start at the empty slot");
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_valid) |=> (busy || out_valid))
    else $error("accepted word neither worked on nor answered");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bfa_pkg::ST_OK) |-> out_block_offset == '0)
    else $error("failed result carries an offset");
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (busy && k_r == '0))
    else $error("cfg write did not restart the clear");
endmodule
`default_nettype wire

@@ tb/tb_best_fit_block_allocator.sv @@
// Testbench for the best-fit block allocator: directed and random allocate/release traffic.
`timescale 1ns / 1ps
`default_nettype none

module tb_best_fit_block_allocator;
  localparam int SW = bfa_pkg::SW;
  localparam int NH = bfa_pkg::NUM_HEADERS_DEF;
  localparam int N_RANDOM = 1530;
  localparam int STALL_LIMIT = 20000;  // covers the slowest request plus a clear

  // Expected-result store plus checker. Holds {status, offset} words in order.
  class alloc_scoreboard;
    logic [1:0]    exp_status[$];
    logic [SW-1:0] exp_offset[$];
    int errors = 0;

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void note(logic [1:0] st, logic [SW-1:0] off);
      exp_status.push_back(st);
      exp_offset.push_back(off);
    endfunction

    task check(input logic [1:0] st, input logic [SW-1:0] off);
      logic [1:0] es;
      logic [SW-1:0] eo;
      if (exp_status.size() == 0) begin
        report($sformatf("unexpected result status=%0d offset=%0d", st, off));
        return;
      end
      es = exp_status.pop_front();
      eo = exp_offset.pop_front();
      if (st !== es) report($sformatf("status got %0d want %0d", st, es));
      if (off !== eo) report($sformatf("offset got %0d want %0d", off, eo));
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_operation;
  logic [SW-1:0] in_request_size;
  logic [SW-1:0] in_release_offset;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [SW-1:0] out_block_offset;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [SW-1:0] cfg_data;

  best_fit_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_release_offset(in_release_offset), .out_valid(out_valid),
    .out_status(out_status), .out_block_offset(out_block_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  alloc_scoreboard sb = new();

  // Predictor copy of the header table.
  logic [SW-1:0] hdr_size[NH];
  logic          hdr_free[NH];
  logic [SW-1:0] arena;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_table();
    for (int k = 0; k < NH; k++) begin
      hdr_size[k] = '0;
      hdr_free[k] = 1'b1;
    end
    hdr_size[0] = arena;
  endfunction

  function automatic bit slot_is_empty(int k);
    return hdr_free[k] && hdr_size[k] == 0;
  endfunction

  // Walk down over empty slots; stop at an allocated block or a free block.
  function automatic int find_lower(int i);
    for (int k = i - 1; k >= 0; k--) begin
      if (!hdr_free[k]) return (k + 1 != i) ? k + 1 : -1;
      if (hdr_size[k] != 0) return k;
    end
    return -1;
  endfunction

  function automatic void predict_alloc(input logic [SW-1:0] req,
                                        output logic [1:0] st, output logic [SW-1:0] off);
    longint run, best_off;
    logic [SW-1:0] best_diff, diff;
    int b, dest, e;
    bit below;
    run = 0; best_off = 0; best_diff = 0; b = -1; below = 0; e = -1;
    st = bfa_pkg::ST_NO_FIT;
    off = '0;
    if (req == 0) return;
    for (int k = 0; k < NH; k++) begin
      if (hdr_free[k] && hdr_size[k] >= req) begin
        diff = hdr_size[k] - req;
        if (diff == 0) begin
          hdr_free[k] = 1'b0;   // exact fit taken at once
          st = bfa_pkg::ST_OK;
          off = run[SW-1:0];
          return;
        end
        if (b < 0 || diff < best_diff) begin
          b = k; best_diff = diff; best_off = run;
        end
      end
      run += hdr_size[k];
    end
    if (b < 0) return;
    dest = find_lower(b);
    if (dest >= 0) below = 1;
    else if (b + 1 < NH && hdr_free[b+1]) dest = b + 1;
    else begin
      for (int k = NH - 1; k >= 0; k--) if (slot_is_empty(k)) e = k;
      if (e < 0) begin
        // no slot for the leftover: granted unsplit
        hdr_free[b] = 1'b0;
        st = bfa_pkg::ST_OK;
        off = best_off[SW-1:0];
        return;
      end
      if (e < b) begin
        for (int k = e; k < b; k++) begin
          hdr_size[k] = hdr_size[k+1]; hdr_free[k] = hdr_free[k+1];
        end
        dest = b; b = b - 1;
      end else begin
        for (int k = e; k > b + 1; k--) begin
          hdr_size[k] = hdr_size[k-1]; hdr_free[k] = hdr_free[k-1];
        end
        dest = b + 1;
      end
      hdr_size[dest] = '0;
      hdr_free[dest] = 1'b1;
    end
    hdr_size[b] = hdr_size[b] - best_diff;
    hdr_size[dest] = hdr_size[dest] + best_diff;
    hdr_free[b] = 1'b0;
    st = bfa_pkg::ST_OK;
    best_off = best_off + (below ? best_diff : 0);
    off = best_off[SW-1:0];
  endfunction

  function automatic void predict_release(input logic [SW-1:0] where,
                                          output logic [1:0] st, output logic [SW-1:0] off);
    longint run;
    int low;
    run = 0;
    st = bfa_pkg::ST_NOT_FOUND;
    off = '0;
    for (int k = 0; k < NH; k++) begin
      if (run == where && !slot_is_empty(k)) begin
        hdr_free[k] = 1'b1;
        if (k + 1 < NH && hdr_free[k+1]) begin
          hdr_size[k] = hdr_size[k] + hdr_size[k+1];
          hdr_size[k+1] = '0;
        end
        low = find_lower(k);
        if (low >= 0) begin
          hdr_size[low] = hdr_size[low] + hdr_size[k];
          hdr_size[k] = '0;
        end
        st = bfa_pkg::ST_OK;
        return;
      end
      run += hdr_size[k];
    end
  endfunction

  // Offset of a random non-empty block, for well-formed releases.
  function automatic logic [SW-1:0] pick_block_offset(bit want_busy);
    longint run;
    logic [SW-1:0] hits[$];
    run = 0;
    for (int k = 0; k < NH; k++) begin
      if (!slot_is_empty(k) && (!want_busy || !hdr_free[k])) hits.push_back(run[SW-1:0]);
      run += hdr_size[k];
    end
    if (hits.size() == 0) return '0;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  // Results are sampled at the rising edge; the checker flags strays itself.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_status, out_block_offset);
  end

  // Watchdog: cycles with no word moving on any side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic gap(input int n);
    repeat (n) @(negedge clk);
  endtask

  // Issue one request word and predict its result at acceptance.
  task automatic send_op(input logic op, input logic [SW-1:0] req, input logic [SW-1:0] where);
    logic [1:0] st;
    logic [SW-1:0] off;
    int n;
    n = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 13));
    if (n > 0) begin
      start <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_request_size <= SW'($urandom);
      in_release_offset <= SW'($urandom);
      gap(n);
    end
    start <= 1'b1;
    in_operation <= op;
    in_request_size <= req;
    in_release_offset <= where;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == bfa_pkg::OP_RELEASE) predict_release(where, st, off);
    else predict_alloc(req, st, off);
    sb.note(st, off);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    gap(16);
  endtask

  task automatic write_arena(input logic [SW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arena = v;
    clear_table();
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= SW'($urandom);
  endtask

  // Mostly well-formed traffic sized against the arena, plus noise.
  task automatic random_phase(input int n);
    logic [SW-1:0] sz;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        sz = (arena > 8) ? SW'($urandom_range(1, (arena >> 3) + 1))
                         : SW'($urandom_range(0, 3));
        send_op(bfa_pkg::OP_ALLOC, sz, SW'($urandom));
      end else if (r < 85) begin
        send_op(bfa_pkg::OP_RELEASE, SW'($urandom),
                pick_block_offset($urandom_range(0, 4) != 0));
      end else if (r < 92) begin
        send_op(bfa_pkg::OP_ALLOC, SW'($urandom), SW'($urandom));
      end else begin
        send_op(bfa_pkg::OP_RELEASE, SW'($urandom), SW'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = bfa_pkg::OP_ALLOC;
    in_request_size = '0;
    in_release_offset = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    arena = bfa_pkg::ARENA_RESET;
    clear_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset arena, zero size, exact fit, oversize, bad release.
    send_op(bfa_pkg::OP_ALLOC, 24'd0, 24'd0);
    send_op(bfa_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
    send_op(bfa_pkg::OP_ALLOC, 24'd100, 24'd0);
    send_op(bfa_pkg::OP_ALLOC, 24'd200, 24'd0);
    send_op(bfa_pkg::OP_ALLOC, 24'd300, 24'd0);
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd100);     // free middle block
    send_op(bfa_pkg::OP_ALLOC, 24'd50, 24'd0);        // leftover goes to lower/upper neighbor
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd100);
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd100);     // release of already free block
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd7);       // offset not found
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'hFFFFFF);
    send_op(bfa_pkg::OP_ALLOC, 24'd65536, 24'd0);

    // Exhaust headers with tiny blocks so the unsplit grant appears.
    write_arena(24'd64);
    for (int i = 0; i < 34; i++) send_op(bfa_pkg::OP_ALLOC, 24'd1, 24'd0);
    for (int i = 0; i < 8; i++) send_op(bfa_pkg::OP_RELEASE, 24'd0, pick_block_offset(1));
    send_op(bfa_pkg::OP_ALLOC, 24'd2, 24'd0);

    write_arena(24'd0);
    send_op(bfa_pkg::OP_ALLOC, 24'd1, 24'd0);
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd0);

    write_arena(24'hFFFFFF);
    send_op(bfa_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
    send_op(bfa_pkg::OP_RELEASE, 24'd0, 24'd0);
    random_phase(N_RANDOM / 4);

    write_arena(24'd200);
    random_phase(N_RANDOM / 4);
    write_arena(bfa_pkg::ARENA_RESET);
    random_phase(N_RANDOM / 4);
    write_arena(SW'($urandom_range(1, 24'hFFFFFF)));
    random_phase(N_RANDOM / 4);

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
